FILE: src/fhdp_pkg.sv
package fhdp_pkg;

    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 512;
    localparam int MAX_DEPTH  = 1024;
    localparam int VOXEL_BITS = 32;

    localparam int COL_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int SLICE_W   = $clog2(MAX_DEPTH);
    localparam int MAP_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;

    // Field and register widths fixed by the interface.
    localparam int VOXEL_W      = 32;
    localparam int LEVEL_W      = 10;
    localparam int THRESH_W     = 32;
    localparam int WIDTH_REG_W  = 10;
    localparam int HEIGHT_REG_W = 10;
    localparam int DEPTH_REG_W  = 11;
    localparam int CFG_DATA_W   = 32;
    localparam int CFG_IDX_W    = 2;
    localparam int S_TDATA_W    = 32;
    localparam int M_TDATA_W    = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD    = 2'd0,
        REG_IMAGE_WIDTH  = 2'd1,
        REG_IMAGE_HEIGHT = 2'd2,
        REG_VOLUME_DEPTH = 2'd3
    } fhdp_reg_idx_t;

    // One accepted voxel as handed from the position logic to the map update.
    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [SLICE_W-1:0] slice;
        logic               hit;
        logic               last_slice;
        logic               last_voxel;
    } fhdp_item_t;

endpackage

FILE: src/fhdp_ram.sv
module fhdp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: src/fhdp_front.sv
module fhdp_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [fhdp_pkg::CFG_IDX_W-1:0]     cfg_wr_index,
    input  logic [fhdp_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  logic                               in_accept,
    input  logic [fhdp_pkg::VOXEL_W-1:0]       voxel_value,
    input  logic                               start_of_volume,
    output fhdp_pkg::fhdp_item_t               item
);
    import fhdp_pkg::*;

    logic signed [THRESH_W-1:0] threshold_reg;
    logic [COL_W-1:0]   w_m1_reg;
    logic [ROW_W-1:0]   h_m1_reg;
    logic [SLICE_W-1:0] d_m1_reg;
    logic [COL_W-1:0]   col_reg, col_next, col_eff;
    logic [ROW_W-1:0]   row_reg, row_next, row_eff;
    logic [SLICE_W-1:0] slice_reg, slice_next, slice_eff;
    logic [WIDTH_REG_W-1:0]  wv;
    logic [HEIGHT_REG_W-1:0] hv;
    logic [DEPTH_REG_W-1:0]  dv;
    logic signed [VOXEL_BITS-1:0] voxel_s;
    logic col_wrap, row_wrap, slice_wrap;

    assign wv = cfg_wr_data[WIDTH_REG_W-1:0];
    assign hv = cfg_wr_data[HEIGHT_REG_W-1:0];
    assign dv = cfg_wr_data[DEPTH_REG_W-1:0];

    // Dimensions are kept as clamped value minus one: zero acts as one,
    // anything above the maximum saturates.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= '0;
            w_m1_reg      <= COL_W'(MAX_WIDTH - 1);
            h_m1_reg      <= ROW_W'(MAX_HEIGHT - 1);
            d_m1_reg      <= SLICE_W'(MAX_DEPTH - 1);
        end else if (cfg_wr_en) begin
            case (fhdp_reg_idx_t'(cfg_wr_index))
                REG_THRESHOLD: begin
                    threshold_reg <= $signed(cfg_wr_data[THRESH_W-1:0]);
                end
                REG_IMAGE_WIDTH: begin
                    if (wv == '0) w_m1_reg <= '0;
                    else if (32'(wv) > MAX_WIDTH) w_m1_reg <= COL_W'(MAX_WIDTH - 1);
                    else w_m1_reg <= COL_W'(wv - 1'b1);
                end
                REG_IMAGE_HEIGHT: begin
                    if (hv == '0) h_m1_reg <= '0;
                    else if (32'(hv) > MAX_HEIGHT) h_m1_reg <= ROW_W'(MAX_HEIGHT - 1);
                    else h_m1_reg <= ROW_W'(hv - 1'b1);
                end
                REG_VOLUME_DEPTH: begin
                    if (dv == '0) d_m1_reg <= '0;
                    else if (32'(dv) > MAX_DEPTH) d_m1_reg <= SLICE_W'(MAX_DEPTH - 1);
                    else d_m1_reg <= SLICE_W'(dv - 1'b1);
                end
                default: begin
                end
            endcase
        end
    end

    // Position of this voxel: a start flag or a shrunken dimension zeroes it.
    always_comb begin
        col_eff   = (start_of_volume || col_reg > w_m1_reg) ? '0 : col_reg;
        row_eff   = (start_of_volume || row_reg > h_m1_reg) ? '0 : row_reg;
        slice_eff = (start_of_volume || slice_reg > d_m1_reg) ? '0 : slice_reg;
        col_wrap   = (col_eff == w_m1_reg);
        row_wrap   = (row_eff == h_m1_reg);
        slice_wrap = (slice_eff == d_m1_reg);
        col_next   = col_wrap ? '0 : col_eff + 1'b1;
        row_next   = row_eff;
        slice_next = slice_eff;
        if (col_wrap) begin
            row_next = row_wrap ? '0 : row_eff + 1'b1;
            if (row_wrap) begin
                slice_next = slice_wrap ? '0 : slice_eff + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            row_reg   <= '0;
            slice_reg <= '0;
        end else if (in_accept) begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            slice_reg <= slice_next;
        end
    end

    assign voxel_s = $signed(voxel_value[VOXEL_BITS-1:0]);

    always_comb begin
        item.addr       = ADDR_W'(row_eff) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col_eff);
        item.slice      = slice_eff;
        item.hit        = (voxel_s > threshold_reg);
        item.last_slice = slice_wrap;
        item.last_voxel = slice_wrap && row_wrap && col_wrap;
    end

endmodule

FILE: src/fhdp_update.sv
module fhdp_update (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               in_accept,
    input  fhdp_pkg::fhdp_item_t               in_item,
    output logic                               in_ready,
    input  logic [fhdp_pkg::SLICE_W-1:0]       ram_rd_data,
    output logic                               ram_wr_en,
    output logic [fhdp_pkg::ADDR_W-1:0]        ram_wr_addr,
    output logic [fhdp_pkg::SLICE_W-1:0]       ram_wr_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [fhdp_pkg::LEVEL_W-1:0]       m_level,
    output logic                               m_final,
    output logic                               m_last
);
    import fhdp_pkg::*;

    logic                s1_valid_reg, s1_valid_next;
    fhdp_item_t          s1_item_reg;
    logic                s1_fwd_reg;
    logic [SLICE_W-1:0]  s1_fwd_data_reg;
    logic                s1_fire;
    logic [SLICE_W-1:0]  old_level, new_level;
    logic                out_valid_reg, out_valid_next;
    logic [LEVEL_W-1:0]  out_level_reg;
    logic                out_final_reg, out_last_reg;

    // The entry written in the cycle of a read is taken from the forward path.
    assign old_level = s1_fwd_reg ? s1_fwd_data_reg : ram_rd_data;

    always_comb begin
        if (s1_item_reg.slice == '0) begin
            new_level = '0;
        end else if (s1_item_reg.hit && old_level == '0) begin
            new_level = s1_item_reg.slice;
        end else begin
            new_level = old_level;
        end
    end

    assign s1_fire  = s1_valid_reg && (!out_valid_reg || m_ready);
    assign in_ready = !s1_valid_reg || s1_fire;

    assign ram_wr_en   = s1_fire;
    assign ram_wr_addr = s1_item_reg.addr;
    assign ram_wr_data = new_level;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (in_accept) s1_valid_next = 1'b1;
        else if (s1_fire) s1_valid_next = 1'b0;
        out_valid_next = out_valid_reg;
        if (s1_fire) out_valid_next = 1'b1;
        else if (m_ready) out_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            s1_item_reg     <= in_item;
            s1_fwd_reg      <= s1_fire && (s1_item_reg.addr == in_item.addr);
            s1_fwd_data_reg <= new_level;
        end
        if (s1_fire) begin
            out_level_reg <= LEVEL_W'(new_level);
            out_final_reg <= s1_item_reg.last_slice;
            out_last_reg  <= s1_item_reg.last_voxel;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_level = out_level_reg;
    assign m_final = out_final_reg;
    assign m_last  = out_last_reg;

endmodule

FILE: src/first_hit_depth_projection.sv
// First-hit depth projection of a signed 32-bit voxel stream.
// Voxels enter on the s_ stream in slice, row, column order, one per transfer:
// s_tdata carries the voxel sample and s_tuser the start-of-volume flag,
// which sets the column, row and slice counters to zero before that voxel.
// Every voxel yields one result transfer on the m_ stream: m_tdata holds the
// pixel's first-hit slice so far (0 means no hit yet), m_tuser is high when
// the voxel lies in the last slice, so the value is final, and m_tlast marks
// the last voxel of the volume. The pass over slice 0 clears each map entry.
// Configuration (threshold and the three dimensions) is written through the
// cfg_wr_ port while no transfer is in flight.
// A transferred voxel waits in the update stage beside its map entry, read
// out of the memory, then in the result register that drives m_. Throughput
// is one voxel per cycle while m_tready stays high, set by the one read port
// and the one write port of the depth map memory, with a forward path for
// back-to-back voxels on one entry. Reset clears the counters, the
// configuration and both pipeline stages; the map itself is not cleared and
// holds meaningful values only after a slice 0 pass. When the receiver
// stalls, the result register and the stage behind it fill, after which
// s_tready falls until m_tready returns.
module first_hit_depth_projection (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [fhdp_pkg::S_TDATA_W-1:0]     s_tdata,   // [31:0] voxel_value
    input  logic                               s_tuser,   // [0] start_of_volume
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [fhdp_pkg::M_TDATA_W-1:0]     m_tdata,   // [9:0] depth_level, rest zero
    output logic                               m_tuser,   // [0] final_for_pixel
    output logic                               m_tlast,   // end_of_volume
    input  logic                               cfg_wr_en,
    input  logic [fhdp_pkg::CFG_IDX_W-1:0]     cfg_wr_index,
    input  logic [fhdp_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);
    import fhdp_pkg::*;

    logic               in_accept;
    fhdp_item_t         item;
    logic [SLICE_W-1:0] ram_rd_data;
    logic               ram_wr_en;
    logic [ADDR_W-1:0]  ram_wr_addr;
    logic [SLICE_W-1:0] ram_wr_data;
    logic [LEVEL_W-1:0] level;

    assign in_accept = s_tvalid && s_tready;

    // Position counters, configuration registers and the threshold compare.
    fhdp_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_index    (cfg_wr_index),
        .cfg_wr_data     (cfg_wr_data),
        .in_accept       (in_accept),
        .voxel_value     (s_tdata[VOXEL_W-1:0]),
        .start_of_volume (s_tuser),
        .item            (item)
    );

    // The map is read as the voxel is accepted and written back when the update stage passes it on.
    fhdp_ram #(
        .WIDTH (SLICE_W),
        .DEPTH (MAP_DEPTH)
    ) u_map (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (in_accept),
        .rd_addr (item.addr),
        .rd_data (ram_rd_data)
    );

    // Map update and the result register.
    fhdp_update u_update (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_accept   (in_accept),
        .in_item     (item),
        .in_ready    (s_tready),
        .ram_rd_data (ram_rd_data),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .m_level     (level),
        .m_final     (m_tuser),
        .m_last      (m_tlast)
    );

    assign m_tdata = M_TDATA_W'(level);

endmodule

FILE: src/fhdp_checker.sv
module fhdp_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [fhdp_pkg::M_TDATA_W-1:0]     m_tdata,
    input logic                               m_tuser,
    input logic                               m_tlast
);

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // With the result register empty the pipeline can always take a voxel.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output empty");

    // A result that appears in an empty output had its input transfer pass
    // straight through the update stage into the result register.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without matching input transfer");

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind first_hit_depth_projection fhdp_checker u_fhdp_checker (.*);

FILE: dv/testbench.sv
module testbench;

    import fhdp_pkg::*;

    // Scoreboard: keeps its own copy of the depth map, the position counters
    // and the four configuration registers. Every accepted voxel advances that
    // state and queues the one result it must produce. Every result transfer
    // is then compared with the oldest queued result.
    class depth_scoreboard;

        typedef struct {
            logic [LEVEL_W-1:0] depth_level;
            logic               final_for_pixel;
            logic               end_of_volume;
        } depth_result_t;

        bit [LEVEL_W-1:0]   level_map [MAP_DEPTH];
        // Set once a slice 0 pass has written the entry. The hardware map is
        // not cleared by reset, so an entry without this bit must never be read.
        bit                 cleared [MAP_DEPTH];
        int unsigned        col_cnt    = 0;
        int unsigned        row_cnt    = 0;
        int unsigned        slice_cnt  = 0;
        logic signed [31:0] threshold  = '0;
        int unsigned        width_reg  = MAX_WIDTH;
        int unsigned        height_reg = MAX_HEIGHT;
        int unsigned        depth_reg  = MAX_DEPTH;
        depth_result_t      pending_q [$];
        int unsigned        n_voxels   = 0;
        int unsigned        n_checked  = 0;
        int unsigned        n_final    = 0;
        int unsigned        n_vol_end  = 0;
        int unsigned        n_mismatch = 0;

        // A dimension of zero acts as one; one above the maximum saturates.
        function int unsigned fit_dim(int unsigned v, int unsigned maxv);
            if (v == 0)
                return 1;
            return (v > maxv) ? maxv : v;
        endfunction

        function void write_reg(fhdp_reg_idx_t idx, logic [31:0] val);
            case (idx)
                REG_THRESHOLD:    threshold  = val;
                REG_IMAGE_WIDTH:  width_reg  = val[WIDTH_REG_W-1:0];
                REG_IMAGE_HEIGHT: height_reg = val[HEIGHT_REG_W-1:0];
                REG_VOLUME_DEPTH: depth_reg  = val[DEPTH_REG_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned voxels_per_volume();
            return fit_dim(width_reg, MAX_WIDTH) * fit_dim(height_reg, MAX_HEIGHT)
                 * fit_dim(depth_reg, MAX_DEPTH);
        endfunction

        function int unsigned pending();
            return pending_q.size();
        endfunction

        // Position the next voxel lands on: the start flag zeroes all
        // counters, and a counter left out of range by a narrower setting
        // restarts at zero.
        function void locate(logic sof, output int unsigned c, output int unsigned r,
                             output int unsigned s);
            c = sof ? 0 : col_cnt;
            r = sof ? 0 : row_cnt;
            s = sof ? 0 : slice_cnt;
            if (c >= fit_dim(width_reg, MAX_WIDTH))
                c = 0;
            if (r >= fit_dim(height_reg, MAX_HEIGHT))
                r = 0;
            if (s >= fit_dim(depth_reg, MAX_DEPTH))
                s = 0;
        endfunction

        function bit reads_uncleared(logic sof);
            int unsigned c, r, s;
            locate(sof, c, r, s);
            return (s != 0) && !cleared[r * MAX_WIDTH + c];
        endfunction

        function void note_voxel(logic [31:0] voxel, logic sof);
            int unsigned   c, r, s, w, h, d, addr;
            depth_result_t res;
            w = fit_dim(width_reg, MAX_WIDTH);
            h = fit_dim(height_reg, MAX_HEIGHT);
            d = fit_dim(depth_reg, MAX_DEPTH);
            locate(sof, c, r, s);
            addr = r * MAX_WIDTH + c;
            if (s == 0) begin
                level_map[addr] = '0;
                cleared[addr]   = 1'b1;
            end else if ($signed(voxel) > threshold && level_map[addr] == 0) begin
                level_map[addr] = LEVEL_W'(s);
            end
            res.depth_level     = level_map[addr];
            res.final_for_pixel = (s == d - 1);
            res.end_of_volume   = res.final_for_pixel && (r == h - 1) && (c == w - 1);
            pending_q.push_back(res);
            n_voxels++;
            c++;
            if (c >= w) begin
                c = 0;
                r++;
                if (r >= h) begin
                    r = 0;
                    s++;
                    if (s >= d)
                        s = 0;
                end
            end
            col_cnt   = c;
            row_cnt   = r;
            slice_cnt = s;
        endfunction

        function void check_result(logic [LEVEL_W-1:0] level, logic fin, logic eov);
            depth_result_t want;
            if (pending_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("ERROR @%0t: spare result level=%0d final=%b eov=%b",
                             $time, level, fin, eov);
                return;
            end
            want = pending_q.pop_front();
            n_checked++;
            if (want.final_for_pixel)
                n_final++;
            if (want.end_of_volume)
                n_vol_end++;
            if (level !== want.depth_level || fin !== want.final_for_pixel
                    || eov !== want.end_of_volume) begin
                n_mismatch++;
                if (n_mismatch <= 10) begin
                    $write("ERROR @%0t: result %0d: expected level=%0d final=%b eov=%b,",
                           $time, n_checked, want.depth_level, want.final_for_pixel,
                           want.end_of_volume);
                    $display(" got level=%0d final=%b eov=%b", level, fin, eov);
                end
            end
        endfunction

    endclass

    localparam int CLK_HALF        = 6;
    localparam int CLK_PERIOD      = 2 * CLK_HALF;
    localparam int RANDOM_ITEMS    = 1830;
    localparam int WATCHDOG_CYCLES = 300_000;

    logic                  aclk         = 1'b0;
    logic                  aresetn      = 1'b0;
    logic                  s_tvalid     = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata      = '0;     // [31:0] voxel_value
    logic                  s_tuser      = 1'b0;   // [0] start_of_volume
    logic                  m_tvalid;
    logic                  m_tready     = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;               // [9:0] depth_level, rest zero
    logic                  m_tuser;               // [0] final_for_pixel
    logic                  m_tlast;               // end_of_volume
    logic                  cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data  = '0;

    // Chance in a hundred that the sender holds back a cycle, and that the
    // receiver refuses a cycle. Changed as the random part progresses.
    int unsigned src_gap_pct    = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned rnd_sent       = 0;
    int unsigned n_settings     = 0;

    depth_scoreboard depth_sb = new();

    first_hit_depth_projection DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // Receiver back-pressure: a fresh decision every cycle.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Every result transfer is checked at the edge on which it happens. The
    // values read here are those from before the edge, so the check does not
    // depend on the order in which processes run.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            depth_sb.check_result(m_tdata[LEVEL_W-1:0], m_tuser, m_tlast);
    end

    // Offers one voxel and returns at the edge of its transfer. It is always
    // entered just after a rising edge, so s_tvalid receives a single
    // assignment per time step: lowered for a gap, or raised for the voxel.
    task automatic send_voxel(logic [31:0] val, logic sof);
        while (src_gap_pct != 0 && $urandom_range(99) < src_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        // An entry that no slice 0 pass has written holds junk in the map, so
        // a voxel that would read one starts a new volume instead.
        if (depth_sb.reads_uncleared(sof))
            sof = 1'b1;
        s_tvalid <= 1'b1;
        s_tdata  <= val;
        s_tuser  <= sof;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        depth_sb.note_voxel(val, sof);
    endtask

    // Idling in thirds: sender gaps light and receiver stalls heavy, then
    // the reverse, then a clean stream at full rate.
    task automatic send_random(logic [31:0] val, logic sof);
        if (rnd_sent < RANDOM_ITEMS / 3) begin
            src_gap_pct    = 25;
            sink_stall_pct = 50;
        end else if (rnd_sent < 2 * RANDOM_ITEMS / 3) begin
            src_gap_pct    = 50;
            sink_stall_pct = 25;
        end else begin
            src_gap_pct    = 0;
            sink_stall_pct = 0;
        end
        send_voxel(val, sof);
        rnd_sent++;
    endtask

    // Registers are only written with nothing in flight: the stream is
    // parked and every outstanding result must have been transferred first.
    // One register per cycle, the enable staying high across the burst.
    task automatic configure(logic [31:0] thr, logic [31:0] wid, logic [31:0] hgt,
                             logic [31:0] dep);
        fhdp_reg_idx_t order [4] = '{REG_THRESHOLD, REG_IMAGE_WIDTH,
                                     REG_IMAGE_HEIGHT, REG_VOLUME_DEPTH};
        logic [31:0]   vals [4];
        vals = '{thr, wid, hgt, dep};
        s_tvalid <= 1'b0;
        while (depth_sb.pending() != 0)
            @(posedge aclk);
        for (int i = 0; i < 4; i++) begin
            cfg_wr_en    <= 1'b1;
            cfg_wr_index <= order[i];
            cfg_wr_data  <= vals[i];
            @(posedge aclk);
            depth_sb.write_reg(order[i], vals[i]);
        end
        cfg_wr_en <= 1'b0;
        n_settings++;
    endtask

    // Bits above a register's width must be ignored by the block.
    function automatic logic [31:0] add_stray_bits(logic [31:0] val, int unsigned used_bits);
        if ($urandom_range(2) == 0)
            return val | ($urandom() << used_bits);
        return val;
    endfunction

    // Mostly values right around the threshold, where the strict comparison
    // decides, with the signed extremes and uniform values mixed in.
    function automatic logic [31:0] pick_voxel(logic [31:0] thr);
        case ($urandom_range(9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3:    return $urandom();
            default: return thr + $urandom_range(4) - 2;
        endcase
    endfunction

    // Small images and short volumes so that volumes complete often. Most
    // of the traffic is whole volumes; the rest is cut-short volumes and
    // stray start flags. A phase often ends mid volume, so the next setting
    // lands mid volume too.
    task automatic run_small_phase();
        logic [31:0] thr;
        int unsigned wid, hgt, dep, budget, done, len, vol, roll;
        logic        sof;
        case ($urandom_range(4))
            0:       thr = '0;
            1:       thr = 32'h7FFF_FFFF;
            2:       thr = 32'h8000_0000;
            default: thr = $urandom();
        endcase
        roll = $urandom_range(19);
        wid  = (roll == 0) ? 0 : (roll == 1) ? $urandom_range(1023, 513) : $urandom_range(6, 1);
        roll = $urandom_range(19);
        hgt  = (roll == 0) ? 0 : (roll == 1) ? $urandom_range(1023, 513) : $urandom_range(4, 1);
        roll = $urandom_range(19);
        dep  = (roll == 0) ? 0 : (roll == 1) ? $urandom_range(2047, 1025) : $urandom_range(8, 1);
        configure(thr, add_stray_bits(wid, WIDTH_REG_W), add_stray_bits(hgt, HEIGHT_REG_W),
                  add_stray_bits(dep, DEPTH_REG_W));
        budget = $urandom_range(130, 50);
        done   = 0;
        while (done < budget) begin
            vol  = depth_sb.voxels_per_volume();
            roll = $urandom_range(99);
            if (roll < 70)
                len = vol;
            else if (roll < 90)
                len = $urandom_range(vol, 1);
            else
                len = 1;
            if (len > 200)
                len = $urandom_range(200, 1);
            sof = (roll < 90) ? ($urandom_range(4) != 0) : ($urandom_range(3) == 0);
            for (int i = 0; i < len; i++) begin
                send_random(pick_voxel(thr), (i == 0) ? sof : ($urandom_range(199) == 0));
                done++;
            end
        end
    endtask

    // A full row and three voxels more at the saturated width: height and depth of
    // zero act as one, so every result is final and the 512th closes the volume.
    task automatic run_wide_phase();
        logic [31:0] thr;
        thr = $urandom();
        configure(thr, add_stray_bits($urandom_range(1023, 513), WIDTH_REG_W),
                  add_stray_bits(0, HEIGHT_REG_W), add_stray_bits(0, DEPTH_REG_W));
        for (int i = 0; i < MAX_WIDTH + 3; i++)
            send_random(pick_voxel(thr), i == 0);
    endtask

    // One pixel through the saturated depth of 1024 slices. Nothing exceeds
    // the threshold before a late slice, so the depth level lands in the upper
    // half of its range, and half the time the first hit is in the last slice.
    task automatic run_deep_phase();
        logic [31:0] thr, val;
        int unsigned hit_at;
        thr    = $urandom_range(2_000_000_000) - 1_000_000_000;
        hit_at = ($urandom_range(1) != 0) ? MAX_DEPTH - 1 : $urandom_range(MAX_DEPTH - 2, 512);
        configure(thr, 1, add_stray_bits(1, HEIGHT_REG_W), add_stray_bits(2047, DEPTH_REG_W));
        for (int i = 0; i < MAX_DEPTH + 6; i++) begin
            if (i < hit_at)
                val = thr - $urandom_range(1000);
            else if (i == hit_at)
                val = thr + 1 + $urandom_range(1000);
            else
                val = $urandom();
            send_random(val, i == 0);
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part, at full rate on both sides.
        // Reset setting (512 x 512 x 1024): the opening voxels of slice 0.
        send_voxel(32'h7FFF_FFFF, 1'b1);
        send_voxel(32'h8000_0000, 1'b0);
        send_voxel(32'h0000_0000, 1'b0);

        // Two columns, one row, three slices, threshold zero. Slice 0 clears
        // both entries whatever the voxel; in slice 1 column 0 hits and column
        // 1 equals the threshold, which is no hit; in slice 2 column 0 keeps
        // its level and column 1 hits late. The last transfer closes the
        // volume, and the one after wraps to slice 0 with no start flag.
        configure(32'h0000_0000, 2, 1, 3);
        send_voxel(32'd5, 1'b1);
        send_voxel(-32'sd5, 1'b0);
        send_voxel(32'd1, 1'b0);
        send_voxel(32'd0, 1'b0);
        send_voxel(32'h8000_0000, 1'b0);
        send_voxel(32'h7FFF_FFFF, 1'b0);
        send_voxel(32'd7, 1'b0);

        // All dimensions zero act as one: each voxel is a whole volume.
        configure(32'h7FFF_FFFF, 0, 0, 0);
        send_voxel(32'h7FFF_FFFF, 1'b0);
        send_voxel(32'h8000_0000, 1'b1);

        // Lowest threshold: the minimum value itself is no hit.
        configure(32'h8000_0000, 1, 1, 4);
        send_voxel(32'd3, 1'b1);
        send_voxel(32'h8000_0000, 1'b0);
        send_voxel(32'h8000_0001, 1'b0);
        send_voxel(32'hFFFF_FFFF, 1'b0);
        send_voxel(32'd9, 1'b1);
        send_voxel(32'd9, 1'b0);
        send_voxel(32'd9, 1'b0);

        // Depth shrinks under the slice counter mid volume: it restarts at 0.
        configure(32'h8000_0000, 1, 1, 2);
        send_voxel(32'd9, 1'b0);

        // Random part.
        for (int p = 0; rnd_sent < RANDOM_ITEMS; p++) begin
            if (p == 2)
                run_wide_phase();
            else if (p == 4)
                run_deep_phase();
            else
                run_small_phase();
        end

        // Drain: wait for the outstanding results, then a few more cycles
        // so that any surplus transfer would still be caught.
        s_tvalid <= 1'b0;
        for (int k = 0; k < 5000 && depth_sb.pending() != 0; k++)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (depth_sb.pending() != 0) begin
            $display("ERROR: %0d expected results never arrived", depth_sb.pending());
            depth_sb.n_mismatch += depth_sb.pending();
        end

        $display("Streamed %0d voxels through %0d register settings; %0d results checked.",
                 depth_sb.n_voxels, n_settings, depth_sb.n_checked);
        $display("Of those, %0d were in a last slice and %0d closed a volume.",
                 depth_sb.n_final, depth_sb.n_vol_end);
        if (depth_sb.n_mismatch == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches in total", depth_sb.n_mismatch);
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #(WATCHDOG_CYCLES * CLK_PERIOD);
        $display("ERROR: run did not finish in %0d cycles", WATCHDOG_CYCLES);
        $display("TEST FAILED");
        $finish;
    end

endmodule
